// ===== hdl/stll_pkg.sv =====
// ----------------------------------------------------------------------------
// stll_pkg
// Shared types and constants of the symbol table load and lookup unit.
// ----------------------------------------------------------------------------
package stll_pkg;

  typedef enum logic [1:0] {
    STATUS_HIT   = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_NONE  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    PH_SKIP   = 5'b00001,
    PH_ADDR   = 5'b00010,
    PH_SPACES = 5'b00100,
    PH_NAME   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  localparam logic [7:0] ChrNl    = 8'h0A;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] NameMax  = 8'hFF;

  function automatic logic [3:0] nibble_of(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) n = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) n = 4'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) n = 4'(b - 8'h37);
    return n;
  endfunction

endpackage

// ===== hdl/stll_parser.sv =====
// ----------------------------------------------------------------------------
// stll_parser
// Section text parser: emits one table write per complete entry.
// ----------------------------------------------------------------------------
module stll_parser #(
  parameter int unsigned TABLE_DEPTH      = 8192,
  parameter int unsigned SECTION_POS_BITS = 20,
  parameter int unsigned ADDR_DIGITS      = 16,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_valid_i,
  input  logic [7:0]                  text_byte_i,
  input  logic                        section_end_i,
  output logic                        wr_en_o,
  output logic [IdxW-1:0]             wr_idx_o,
  output logic [63:0]                 wr_addr_o,
  output logic [SECTION_POS_BITS-1:0] wr_start_o,
  output logic [7:0]                  wr_len_o,
  output logic [CntW-1:0]             count_o
);
  import stll_pkg::*;

  localparam int unsigned DigW = $clog2(ADDR_DIGITS + 1);

  phase_e                      phase_q, phase_d;
  logic [63:0]                 acc_q, acc_d;
  logic [DigW-1:0]             dig_q, dig_d;
  logic [SECTION_POS_BITS-1:0] pos_q, pos_d, start_q, start_d;
  logic [7:0]                  len_q, len_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        term, sep, commit;

  assign term = (text_byte_i == ChrNl) || (text_byte_i == ChrNul);
  assign sep  = term || (text_byte_i == ChrSpace) || (text_byte_i == ChrTab);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    dig_d   = dig_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    commit  = 1'b0;
    if (byte_valid_i && phase_q != PH_DONE) begin
      pos_d = pos_q + 1'b1;
      unique case (phase_q)
        PH_SKIP: begin
          if (!sep) begin
            acc_d   = {60'd0, nibble_of(text_byte_i)};
            dig_d   = DigW'(1);
            phase_d = (ADDR_DIGITS <= 1) ? PH_SPACES : PH_ADDR;
          end
        end
        PH_ADDR: begin
          acc_d = {acc_q[59:0], nibble_of(text_byte_i)};
          dig_d = dig_q + 1'b1;
          if (dig_d >= DigW'(ADDR_DIGITS)) phase_d = PH_SPACES;
        end
        PH_SPACES: begin
          if (text_byte_i != ChrSpace) begin
            start_d = pos_q;
            if (term) begin
              len_d   = 8'd0;
              phase_d = PH_SKIP;
            end else begin
              len_d   = 8'd1;
              phase_d = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (term) commit = 1'b1;
          else if (len_q != NameMax) len_d = len_q + 1'b1;
        end
        default: phase_d = phase_q;
      endcase
      if (section_end_i && phase_d == PH_NAME) commit = 1'b1;
      if (commit) phase_d = (cnt_q + 1'b1 >= CntW'(TABLE_DEPTH)) ? PH_DONE : PH_SKIP;
      if (section_end_i) phase_d = PH_DONE;
    end
  end

  assign cnt_d      = commit ? cnt_q + 1'b1 : cnt_q;
  assign wr_en_o    = commit;
  assign wr_idx_o   = cnt_q[IdxW-1:0];
  assign wr_addr_o  = acc_d;
  assign wr_start_o = start_d;
  assign wr_len_o   = len_d;
  assign count_o    = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      acc_q   <= '0;
      dig_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dig_q   <= dig_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/symbol_table_load_and_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// symbol_table_load_and_lookup_unit
// Builds a symbol table from streamed section text and resolves addresses.
// ----------------------------------------------------------------------------
// Usage: raise start with op_i=0 to feed one section byte; it is taken
// only while busy is low, leaves busy low and produces no result word. A byte with
// section_end_i closes the section; later bytes are ignored until reset.
// With op_i=1 the unit resolves query_addr_i: busy rises and the unit
// scans the entry memory one entry per cycle through its single read port.
// A lookup runs the scan, check and finish steps before the result (an
// empty table skips check). The result word is shown for one cycle with
// done_o high; the receiver cannot stall, so no backpressure exists. Reset
// clears the entry count and parser state; memory contents need no
// clearing because only entries below the count are read.
// ----------------------------------------------------------------------------
module symbol_table_load_and_lookup_unit #(
  parameter int unsigned TABLE_DEPTH      = 8192,
  parameter int unsigned SECTION_POS_BITS = 20,
  parameter int unsigned ADDR_DIGITS      = 16,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [7:0]                  text_byte_i,
  input  logic                        section_end_i,
  input  logic [63:0]                 query_addr_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [IdxW-1:0]             entry_index_o,
  output logic [63:0]                 entry_addr_o,
  output logic [63:0]                 distance_o,
  output logic [SECTION_POS_BITS-1:0] label_pos_o,
  output logic [7:0]                  label_size_o,
  output logic [CntW-1:0]             entries_loaded_o
);
  import stll_pkg::*;

  localparam int unsigned EntW = 64 + SECTION_POS_BITS + 8;

  logic                        wr_en;
  logic [IdxW-1:0]             wr_idx;
  logic [63:0]                 wr_addr;
  logic [SECTION_POS_BITS-1:0] wr_start;
  logic [7:0]                  wr_len;
  logic [CntW-1:0]             count;

  stll_parser #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .SECTION_POS_BITS(SECTION_POS_BITS),
    .ADDR_DIGITS     (ADDR_DIGITS)
  ) u_parser (
    .clk_i, .rst_ni,
    .byte_valid_i (start && !busy && !op_i),
    .text_byte_i, .section_end_i,
    .wr_en_o (wr_en), .wr_idx_o (wr_idx), .wr_addr_o (wr_addr),
    .wr_start_o (wr_start), .wr_len_o (wr_len), .count_o (count)
  );

  logic [EntW-1:0] mem [TABLE_DEPTH];
  logic [EntW-1:0] rd_q;
  logic [IdxW-1:0] rd_idx;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= {wr_addr, wr_start, wr_len};
    rd_q <= mem[rd_idx];
  end

  // scan state
  logic            scan_q, chk_q, fin_q, found_q;
  logic [CntW-1:0] ridx_q, cidx_q;
  logic [63:0]     q_q, bdist_q;
  logic [EntW-1:0] best_q;
  logic [IdxW-1:0] bidx_q;
  logic [63:0]     ra, d;
  logic            take, last_rd;

  assign busy    = scan_q || chk_q || fin_q;
  assign rd_idx  = ridx_q[IdxW-1:0];
  assign last_rd = (ridx_q + 1'b1 >= count);
  assign ra      = rd_q[EntW-1 -: 64];
  assign d       = q_q - ra;
  assign take    = chk_q && (ra <= q_q) && (!found_q || d < bdist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= 1'b0;
      chk_q   <= 1'b0;
      fin_q   <= 1'b0;
      found_q <= 1'b0;
      ridx_q  <= '0;
      cidx_q  <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      chk_q  <= scan_q && count != '0;
      cidx_q <= ridx_q;
      if (start && !busy && op_i) begin
        scan_q  <= 1'b1;
        found_q <= 1'b0;
        ridx_q  <= '0;
      end else if (scan_q) begin
        ridx_q <= ridx_q + 1'b1;
        if (count == '0 || last_rd) scan_q <= 1'b0;
        if (count == '0) fin_q <= 1'b1;
      end
      if (take) found_q <= 1'b1;
      if (chk_q && !scan_q) fin_q <= 1'b1;
      if (fin_q) begin
        fin_q  <= 1'b0;
        done_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy && op_i) q_q <= query_addr_i;
    if (take) begin
      bdist_q <= d;
      best_q  <= rd_q;
      bidx_q  <= cidx_q[IdxW-1:0];
    end
  end

  always_comb begin
    entries_loaded_o = count;
    status_o      = STATUS_HIT;
    entry_index_o = '0;
    entry_addr_o  = '0;
    distance_o    = '0;
    label_pos_o   = '0;
    label_size_o  = '0;
    if (count == '0) status_o = STATUS_EMPTY;
    else if (!found_q) begin
      status_o   = STATUS_NONE;
      distance_o = '1;
    end else begin
      entry_index_o = bidx_q;
      entry_addr_o  = best_q[EntW-1 -: 64];
      distance_o    = bdist_q;
      label_pos_o   = best_q[8 +: SECTION_POS_BITS];
      label_size_o  = best_q[7:0];
    end
  end

endmodule
